>>> rtl/byte_stuffing_codec_macros.svh
// Assertion macros shared by the byte stuffing codec.
`ifndef BYTE_STUFFING_CODEC_MACROS_SVH
`define BYTE_STUFFING_CODEC_MACROS_SVH

`ifndef ASSERT_OFF
`define BSC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("byte stuffing codec check failed");
`define BSC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("byte stuffing codec check failed in reset");
`else
`define BSC_ASSERT(label, prop)
`define BSC_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> rtl/bsc_pkg.sv
`default_nettype none

package bsc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_MODE       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FLAG_BYTE  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ESC_BYTE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FLAG_SUBST = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ESC_SUBST  = 3'd4;

  localparam logic       MODE_STUFF      = 1'b1;
  localparam logic [7:0] FLAG_BYTE_RST   = 8'h7E;
  localparam logic [7:0] ESC_BYTE_RST    = 8'h7D;
  localparam logic [7:0] FLAG_SUBST_RST  = 8'h5E;
  localparam logic [7:0] ESC_SUBST_RST   = 8'h5D;
  localparam logic [7:0] CHECK_INIT      = 8'h00;

  typedef struct packed {
    logic       mode;
    logic [7:0] flag_byte;
    logic [7:0] escape_byte;
    logic [7:0] flag_substitute;
    logic [7:0] escape_substitute;
  } cfg_t;

  // Up to three output beats for one input byte, plus the state it leaves behind.
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic [2:0]      lasts;
    logic [7:0]      acc_d;
    logic            pend_d;
  } expand_t;

endpackage

`default_nettype wire

>>> rtl/bsc_expand.sv
`default_nettype none

module bsc_expand (
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  input  bsc_pkg::cfg_t   cfg_i,
  input  logic [7:0]      acc_i,
  input  logic            pend_i,
  output bsc_pkg::expand_t exp_o
);
  import bsc_pkg::*;

  logic [7:0] acc_x;
  logic [1:0] n;

  assign acc_x = acc_i ^ data_byte_i;

  always_comb begin
    exp_o       = '0;
    n           = 2'd0;
    exp_o.acc_d = acc_i;
    exp_o.pend_d = pend_i;
    if (cfg_i.mode == MODE_STUFF) begin
      if (data_byte_i == cfg_i.flag_byte) begin
        exp_o.bytes[0] = cfg_i.escape_byte;
        exp_o.bytes[1] = cfg_i.flag_substitute;
        n = 2'd2;
      end else if (data_byte_i == cfg_i.escape_byte) begin
        exp_o.bytes[0] = cfg_i.escape_byte;
        exp_o.bytes[1] = cfg_i.escape_substitute;
        n = 2'd2;
      end else begin
        exp_o.bytes[0] = data_byte_i;
        n = 2'd1;
      end
      if (last_byte_i) begin
        exp_o.bytes[n] = acc_x;
        exp_o.lasts[n] = 1'b1;
        n = n + 2'd1;
        exp_o.acc_d = CHECK_INIT;
      end else begin
        exp_o.acc_d = acc_x;
      end
      exp_o.pend_d = 1'b0;
    end else begin
      if (pend_i) begin
        if (data_byte_i == cfg_i.flag_substitute) begin
          exp_o.bytes[0] = cfg_i.flag_byte;
          exp_o.lasts[0] = last_byte_i;
          n = 2'd1;
          exp_o.pend_d = 1'b0;
        end else if (data_byte_i == cfg_i.escape_substitute) begin
          exp_o.bytes[0] = cfg_i.escape_byte;
          exp_o.lasts[0] = last_byte_i;
          n = 2'd1;
          exp_o.pend_d = 1'b0;
        end else if (data_byte_i == cfg_i.escape_byte) begin
          exp_o.bytes[0] = cfg_i.escape_byte;
          n = 2'd1;
          if (last_byte_i) begin
            exp_o.bytes[1] = cfg_i.escape_byte;
            exp_o.lasts[1] = 1'b1;
            n = 2'd2;
          end
        end else begin
          exp_o.bytes[0] = cfg_i.escape_byte;
          exp_o.bytes[1] = data_byte_i;
          exp_o.lasts[1] = last_byte_i;
          n = 2'd2;
          exp_o.pend_d = 1'b0;
        end
      end else if (data_byte_i == cfg_i.escape_byte && !last_byte_i) begin
        exp_o.pend_d = 1'b1;
      end else begin
        exp_o.bytes[0] = data_byte_i;
        exp_o.lasts[0] = last_byte_i;
        n = 2'd1;
      end
      if (last_byte_i) begin
        exp_o.pend_d = 1'b0;
        exp_o.acc_d  = CHECK_INIT;
      end
    end
    exp_o.count = n;
  end

endmodule

`default_nettype wire

>>> rtl/byte_stuffing_codec.sv
`default_nettype none
`include "byte_stuffing_codec_macros.svh"

// HDLC-style byte stuffing codec. With mode set it escapes flag and escape bytes and
// appends an XOR check byte after the byte marked last; with mode clear it turns escape
// pairs back into the original bytes. Each accepted input byte holds the block until all
// of its output beats, from none to three, have moved into the output register, which
// carries one byte per cycle; an escape that is merely held produces no beat. The next
// input beat is taken in the cycle in which the last beat of the current one moves into
// the output register, so a stream with no escapes runs at one byte per cycle unless the
// output stalls. Configuration must be written only while the block is idle; the block
// does not enforce this. Any write to mode clears the running check byte and held escape.
module byte_stuffing_codec (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   out_byte_o,
  output logic                         out_last_o
);
  import bsc_pkg::*;

  cfg_t       cfg_q;
  logic [7:0] acc_q;
  logic       pend_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic [1:0] idx_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  expand_t    exp;
  logic       out_free;
  logic       out_load;
  logic       done;
  logic       in_accept;

  bsc_expand u_expand (
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .cfg_i       (cfg_q),
    .acc_i       (acc_q),
    .pend_i      (pend_q),
    .exp_o       (exp)
  );

  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = s1_valid_q && (exp.count != 2'd0) && out_free;
  assign done      = s1_valid_q &&
                     ((exp.count == 2'd0) || (out_free && idx_q == exp.count - 2'd1));
  assign in_ready_o = !s1_valid_q || done;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode              <= MODE_STUFF;
      cfg_q.flag_byte         <= FLAG_BYTE_RST;
      cfg_q.escape_byte       <= ESC_BYTE_RST;
      cfg_q.flag_substitute   <= FLAG_SUBST_RST;
      cfg_q.escape_substitute <= ESC_SUBST_RST;
      acc_q                   <= CHECK_INIT;
      pend_q                  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODE: begin
          cfg_q.mode <= cfg_data_i[0];
          acc_q      <= CHECK_INIT;
          pend_q     <= 1'b0;
        end
        REG_FLAG_BYTE:  cfg_q.flag_byte         <= cfg_data_i;
        REG_ESC_BYTE:   cfg_q.escape_byte       <= cfg_data_i;
        REG_FLAG_SUBST: cfg_q.flag_substitute   <= cfg_data_i;
        REG_ESC_SUBST:  cfg_q.escape_substitute <= cfg_data_i;
        default: ;
      endcase
    end else if (done) begin
      acc_q  <= exp.acc_d;
      pend_q <= exp.pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      idx_q      <= 2'd0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (done) begin
        s1_valid_q <= 1'b0;
      end
      if (done) begin
        idx_q <= 2'd0;
      end else if (out_load) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= exp.bytes[idx_q];
      out_last_q <= exp.lasts[idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  `BSC_ASSERT(a_idx_in_range, (s1_valid_q && exp.count != 2'd0) |-> (idx_q < exp.count))
  `BSC_ASSERT(a_stuff_no_pend, (cfg_q.mode == MODE_STUFF) |-> !pend_q)
  `BSC_ASSERT(a_last_clears, (done && s1_last_q) |=> (!pend_q && acc_q == CHECK_INIT))
  `BSC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!out_valid_q && !s1_valid_q))

endmodule

`default_nettype wire

>>> dv/tb_byte_stuffing_codec.sv
`default_nettype none

module tb_byte_stuffing_codec;
  timeunit 1ns;
  timeprecision 1ps;

  import bsc_pkg::*;

  localparam logic                ModeDestuff   = 1'b0;
  localparam logic [CfgIdxW-1:0]  RegFirstSpare = 3'd5;
  localparam logic [CfgIdxW-1:0]  RegLastSpare  = 3'd7;
  localparam int unsigned         DrainCycles   = 8;
  localparam int unsigned         HoldOffCycles = 150;
  localparam int unsigned         WatchdogLimit = 1000;
  localparam int unsigned         NumPhases     = 6;
  localparam int unsigned         ItemsPerPhase = 68;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  class stuffing_scoreboard;
    cfg_t        cfg;
    logic [7:0]  check_acc;
    logic        esc_held;
    out_beat_t   pending_out_beats[$];
    int unsigned errors;

    function new();
      cfg.mode              = MODE_STUFF;
      cfg.flag_byte         = FLAG_BYTE_RST;
      cfg.escape_byte       = ESC_BYTE_RST;
      cfg.flag_substitute   = FLAG_SUBST_RST;
      cfg.escape_substitute = ESC_SUBST_RST;
      check_acc             = CHECK_INIT;
      esc_held              = 1'b0;
      errors                = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] value);
      case (idx)
        REG_MODE: begin
          cfg.mode  = value[0];
          check_acc = CHECK_INIT;
          esc_held  = 1'b0;
        end
        REG_FLAG_BYTE:  cfg.flag_byte         = value;
        REG_ESC_BYTE:   cfg.escape_byte       = value;
        REG_FLAG_SUBST: cfg.flag_substitute   = value;
        REG_ESC_SUBST:  cfg.escape_substitute = value;
        default: ;
      endcase
    endfunction

    function void expect_beat(logic [7:0] data, logic last);
      out_beat_t beat;
      beat.data = data;
      beat.last = last;
      pending_out_beats.push_back(beat);
    endfunction

    function void note_input(logic [7:0] b, logic last);
      if (cfg.mode == MODE_STUFF) begin
        check_acc = check_acc ^ b;
        if (b == cfg.flag_byte) begin
          expect_beat(cfg.escape_byte, 1'b0);
          expect_beat(cfg.flag_substitute, 1'b0);
        end else if (b == cfg.escape_byte) begin
          expect_beat(cfg.escape_byte, 1'b0);
          expect_beat(cfg.escape_substitute, 1'b0);
        end else begin
          expect_beat(b, 1'b0);
        end
        if (last) begin
          expect_beat(check_acc, 1'b1);
          check_acc = CHECK_INIT;
        end
        esc_held = 1'b0;
      end else begin
        if (esc_held) begin
          if (b == cfg.flag_substitute) begin
            expect_beat(cfg.flag_byte, last);
            esc_held = 1'b0;
          end else if (b == cfg.escape_substitute) begin
            expect_beat(cfg.escape_byte, last);
            esc_held = 1'b0;
          end else if (b == cfg.escape_byte) begin
            // The held escape goes out and the new one waits for its partner.
            expect_beat(cfg.escape_byte, 1'b0);
            if (last) begin
              expect_beat(cfg.escape_byte, 1'b1);
              esc_held = 1'b0;
            end
          end else begin
            expect_beat(cfg.escape_byte, 1'b0);
            expect_beat(b, last);
            esc_held = 1'b0;
          end
        end else if (b == cfg.escape_byte && !last) begin
          esc_held = 1'b1;
        end else begin
          expect_beat(b, last);
        end
        if (last) begin
          esc_held  = 1'b0;
          check_acc = CHECK_INIT;
        end
      end
    endfunction

    function void check_output_beat(logic [7:0] b, logic last);
      out_beat_t want;
      if (pending_out_beats.size() == 0) begin
        $error("unexpected output beat: out_byte %02h out_last %0b", b, last);
        errors++;
        return;
      end
      want = pending_out_beats.pop_front();
      if (b !== want.data) begin
        $error("out_byte: expected %02h, actual %02h", want.data, b);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_out_beats.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [7:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               last_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [7:0]         out_byte_o;
  logic               out_last_o;

  stuffing_scoreboard sb;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  logic               hold_request;
  int unsigned        quiet_cycles;

  byte_stuffing_codec dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_output_beat(out_byte_o, out_last_o);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(b, last);
    @(negedge clk_i);
  endtask

  // A held escape yields no beat, so DrainCycles spare cycles follow the last one.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic random_last();
    return ($urandom_range(0, 5) == 0);
  endfunction

  function automatic logic [7:0] pick_data_byte();
    case ($urandom_range(0, 9))
      0, 1:    return sb.cfg.flag_byte;
      2:       return sb.cfg.escape_byte;
      3:       return sb.cfg.flag_substitute;
      4:       return sb.cfg.escape_substitute;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic apply_phase_config(input int unsigned phase_idx);
    logic       mode;
    logic [7:0] flag, esc, fsub, esub;
    mode = (phase_idx % 2 == 0) ? MODE_STUFF : ModeDestuff;
    case (phase_idx)
      0: begin flag = 8'h00; esc = 8'hFF; fsub = 8'h01; esub = 8'hFE; end
      1: begin flag = 8'h00; esc = 8'hFF; fsub = 8'h00; esub = 8'hFF; end
      3: begin flag = 8'hFF; esc = 8'h00; fsub = 8'hFF; esub = 8'h00; end
      default: begin
        flag = 8'($urandom_range(0, 255));
        esc  = 8'($urandom_range(0, 255));
        fsub = 8'($urandom_range(0, 255));
        esub = ($urandom_range(0, 3) == 0) ? fsub : 8'($urandom_range(0, 255));
      end
    endcase
    write_reg(REG_MODE, {7'($urandom_range(0, 127)), mode});
    write_reg(REG_FLAG_BYTE, flag);
    write_reg(REG_ESC_BYTE, esc);
    write_reg(REG_FLAG_SUBST, fsub);
    write_reg(REG_ESC_SUBST, esub);
    write_reg(3'($urandom_range(RegFirstSpare, RegLastSpare)), 8'($urandom_range(0, 255)));
  endtask

  task automatic run_random_items(input int unsigned count);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      if (sb.cfg.mode == ModeDestuff && $urandom_range(0, 99) < 40) begin
        send_byte(sb.cfg.escape_byte, 1'b0);
        send_byte($urandom_range(0, 1) ? sb.cfg.flag_substitute : sb.cfg.escape_substitute,
                  random_last());
        sent += 2;
      end else begin
        send_byte(pick_data_byte(), random_last());
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_MODE;
    cfg_data_i    = 8'h00;
    in_valid_i    = 1'b0;
    data_byte_i   = 8'h00;
    last_byte_i   = 1'b0;
    out_ready_i   = 1'b0;
    hold_request  = 1'b0;
    quiet_cycles  = 0;
    send_idle_pct = 35;
    recv_idle_pct = 79;
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(FLAG_BYTE_RST, 1'b0);
    send_byte(ESC_BYTE_RST, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(FLAG_BYTE_RST, 1'b1);
    send_byte(8'h11, 1'b0);
    settle();
    // Rewriting the mode in the middle of a buffer drops the running check byte.
    write_reg(REG_MODE, 8'(MODE_STUFF));
    send_byte(8'h22, 1'b1);
    settle();
    write_reg(REG_FLAG_BYTE, ESC_BYTE_RST);
    send_byte(ESC_BYTE_RST, 1'b1);
    settle();
    write_reg(REG_FLAG_BYTE, FLAG_BYTE_RST);
    write_reg(REG_MODE, 8'(ModeDestuff));
    send_byte(ESC_BYTE_RST, 1'b0);
    send_byte(FLAG_SUBST_RST, 1'b0);
    send_byte(ESC_BYTE_RST, 1'b0);
    send_byte(ESC_SUBST_RST, 1'b0);
    send_byte(ESC_BYTE_RST, 1'b0);
    send_byte(ESC_BYTE_RST, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(ESC_BYTE_RST, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(ESC_BYTE_RST, 1'b1);
    send_byte(ESC_BYTE_RST, 1'b0);
    send_byte(ESC_BYTE_RST, 1'b1);
    send_byte(ESC_BYTE_RST, 1'b0);
    settle();
    write_reg(REG_MODE, 8'(ModeDestuff));
    send_byte(FLAG_SUBST_RST, 1'b1);
    settle();
    write_reg(REG_ESC_SUBST, FLAG_SUBST_RST);
    write_reg(RegLastSpare, 8'hA5);
    send_byte(ESC_BYTE_RST, 1'b0);
    send_byte(FLAG_SUBST_RST, 1'b1);
    settle();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p == 2) begin
        send_idle_pct = 79;
        recv_idle_pct = 35;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_phase_config(p);
      if (p == 4) begin
        hold_request = 1'b1;
      end
      run_random_items(ItemsPerPhase);
      settle();
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> byte_stuffing_codec.f
+incdir+rtl
rtl/bsc_pkg.sv
rtl/bsc_expand.sv
rtl/byte_stuffing_codec.sv
dv/tb_byte_stuffing_codec.sv
